### hdl/bssr_pkg.sv
`timescale 1ns / 1ps

package bssr_pkg;

   localparam int DEFAULT_MAX_PATTERN     = 8;
   localparam int DEFAULT_MAX_REPLACEMENT = 8;
   localparam int DEFAULT_QUEUE_DEPTH     = 4;

   // upper bound of both parameters
   localparam int JOB_BYTES  = 8;
   localparam int JOB_IDX_W  = $clog2(JOB_BYTES);
   localparam int CNT_W      = 4;
   localparam int CSR_DATA_W = 64;

   typedef enum logic [1:0] {
      CSR_PATTERN_BYTES      = 2'd0,
      CSR_PATTERN_LENGTH     = 2'd1,
      CSR_REPLACEMENT_BYTES  = 2'd2,
      CSR_REPLACEMENT_LENGTH = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       end_of_output;
   } rsp_item_type;

   // bytes to emit for one input item, oldest in lane 0
   typedef struct packed {
      logic [JOB_BYTES-1:0][7:0] bytes;
      logic [CNT_W-1:0]          count;
      logic                      last;
   } job_type;

endpackage

### hdl/bssr_front.sv
`timescale 1ns / 1ps

module bssr_front #(
   parameter int MAX_PATTERN     = bssr_pkg::DEFAULT_MAX_PATTERN,
   parameter int MAX_REPLACEMENT = bssr_pkg::DEFAULT_MAX_REPLACEMENT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   input  bssr_pkg::req_item_type          req_item,
   input  logic                            csr_valid,
   input  bssr_pkg::csr_index_type         csr_index,
   input  logic [bssr_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            q_full,
   output logic                            q_push,
   output bssr_pkg::job_type               q_job
);
   import bssr_pkg::*;

   localparam int RW = (MAX_REPLACEMENT > 0) ? MAX_REPLACEMENT : 1;

   logic [MAX_PATTERN-1:0][7:0] pattern_ff;
   logic [RW-1:0][7:0]          repl_ff;
   logic [CNT_W-1:0]            plen_raw_ff;
   logic [CNT_W-1:0]            rlen_raw_ff;
   logic [MAX_PATTERN-1:0][7:0] window_ff;
   logic [MAX_PATTERN-1:0][7:0] window_in;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;

   logic [CNT_W-1:0]            plen;
   logic [CNT_W-1:0]            rlen;
   logic [CNT_W-1:0]            slot;
   logic [CNT_W-1:0]            cnt_new;
   logic [MAX_PATTERN-1:0][7:0] win_new;
   logic [MAX_PATTERN-1:0][7:0] win_shift;
   logic                        win_full;
   logic                        hit;
   logic                        fin;
   logic                        accept;

   always_comb begin
      if (plen_raw_ff == '0) begin
         plen = CNT_W'(1);
      end else if (plen_raw_ff > CNT_W'(MAX_PATTERN)) begin
         plen = CNT_W'(MAX_PATTERN);
      end else begin
         plen = plen_raw_ff;
      end
      if (rlen_raw_ff > CNT_W'(MAX_REPLACEMENT)) begin
         rlen = CNT_W'(MAX_REPLACEMENT);
      end else begin
         rlen = rlen_raw_ff;
      end
   end

   assign fin     = req_item.final_byte;
   assign accept  = req_push && !q_full;
   assign slot    = (count_ff >= plen) ? '0 : count_ff;
   assign cnt_new = slot + CNT_W'(1);
   assign win_full = (cnt_new == plen);

   always_comb begin
      hit = win_full;
      for (int i = 0; i < MAX_PATTERN; i++) begin
         win_new[i] = (slot == CNT_W'(i)) ? req_item.data_byte : window_ff[i];
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
         if (CNT_W'(i) < plen && win_new[i] != pattern_ff[i]) begin
            hit = 1'b0;
         end
      end
      for (int i = 0; i < MAX_PATTERN - 1; i++) begin
         win_shift[i] = win_new[i+1];
      end
      win_shift[MAX_PATTERN-1] = win_new[MAX_PATTERN-1];
   end

   always_comb begin
      q_job       = '0;
      q_job.last  = fin;
      window_in   = win_new;
      count_in    = cnt_new;
      if (hit) begin
         for (int i = 0; i < RW; i++) begin
            q_job.bytes[i] = repl_ff[i];
         end
         q_job.count = rlen;
         count_in    = '0;
      end else begin
         for (int i = 0; i < MAX_PATTERN; i++) begin
            q_job.bytes[i] = win_new[i];
         end
         if (win_full) begin
            q_job.count = fin ? plen : CNT_W'(1);
            window_in   = win_shift;
            count_in    = plen - CNT_W'(1);
         end else begin
            q_job.count = fin ? cnt_new : '0;
         end
      end
      if (fin) begin
         count_in = '0;
      end
   end

   assign q_push = accept && (q_job.count != '0 || fin);

   always_ff @(posedge clock) begin
      if (accept) begin
         window_ff <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff  <= '0;
         repl_ff     <= '0;
         plen_raw_ff <= CNT_W'(1);
         rlen_raw_ff <= '0;
         count_ff    <= '0;
      end else begin
         // a new pattern length discards the pending window
         if (csr_valid && csr_index == CSR_PATTERN_LENGTH) begin
            count_ff <= '0;
         end else if (accept) begin
            count_ff <= count_in;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_PATTERN_BYTES: begin
                  pattern_ff <= csr_data[MAX_PATTERN*8-1:0];
               end
               CSR_PATTERN_LENGTH: begin
                  plen_raw_ff <= csr_data[CNT_W-1:0];
               end
               CSR_REPLACEMENT_BYTES: begin
                  repl_ff <= csr_data[RW*8-1:0];
               end
               CSR_REPLACEMENT_LENGTH: begin
                  rlen_raw_ff <= csr_data[CNT_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
   end

endmodule

### hdl/bssr_queue.sv
`timescale 1ns / 1ps

module bssr_queue #(
   parameter int DEPTH = bssr_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bssr_pkg::job_type push_job,
   output logic              full,
   input  logic              pop,
   output bssr_pkg::job_type head_job,
   output logic              empty
);
   import bssr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LVL_W = $clog2(DEPTH + 1);

   job_type            slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [LVL_W-1:0]   level_ff;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      next_ptr = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   assign full     = (level_ff == LVL_W'(DEPTH));
   assign empty    = (level_ff == '0);
   assign head_job = slots_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (push && !pop) begin
            level_ff <= level_ff + LVL_W'(1);
         end else if (pop && !push) begin
            level_ff <= level_ff - LVL_W'(1);
         end
      end
   end

endmodule

### hdl/bssr_back.sv
`timescale 1ns / 1ps

module bssr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  bssr_pkg::job_type      q_job,
   input  logic                   q_empty,
   output logic                   q_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output bssr_pkg::rsp_item_type rsp_item
);
   import bssr_pkg::*;

   logic [JOB_IDX_W-1:0] idx_ff;
   logic [JOB_IDX_W-1:0] idx_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   rsp_item_type         rsp_item_ff;
   rsp_item_type         rsp_item_in;
   logic                 load;
   logic                 take;
   logic                 bare;
   logic                 last_byte;

   assign load      = !rsp_valid_ff || rsp_pop;
   assign take      = load && !q_empty;
   assign bare      = (q_job.count == '0);
   assign last_byte = (CNT_W'(idx_ff) + CNT_W'(1) == q_job.count);
   assign q_pop     = take && (bare || last_byte);

   always_comb begin
      rsp_valid_in = load ? !q_empty : rsp_valid_ff;
      idx_in       = idx_ff;
      if (take) begin
         idx_in = q_pop ? '0 : idx_ff + JOB_IDX_W'(1);
      end
      if (bare) begin
         rsp_item_in.out_byte      = '0;
         rsp_item_in.byte_valid    = 1'b0;
         rsp_item_in.end_of_output = 1'b1;
      end else begin
         rsp_item_in.out_byte      = q_job.bytes[idx_ff];
         rsp_item_in.byte_valid    = 1'b1;
         rsp_item_in.end_of_output = q_job.last && last_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

### hdl/byte_stream_search_replace.sv
`timescale 1ns / 1ps
// Byte stream search and replace.
// Input queue port: req_push / req_full with req_item (data_byte, final_byte).
// Result queue port: rsp_empty / rsp_pop with rsp_item (out_byte, byte_valid,
// end_of_output). Settings port: csr_valid / csr_ready (always ready),
// csr_index, csr_data; write settings only while no stream is in flight.
// The front holds the pattern window and compares it in the cycle a byte is
// taken, producing a list of up to eight bytes per item; a queue of
// QUEUE_DEPTH lists decouples it from the back, which emits one byte a cycle
// into a single output register while rsp_pop keeps up.
// A result passes through a queue slot and then the output register before
// it shows on rsp_item. The front takes one item a cycle while the queue is
// not full, which lasts while items produce at most one byte each; the back
// emits an item's bytes one at a time; req_full rises once the queue is full.
// A stalled rsp_pop holds the result and fills the queue, then raises
// req_full. Reset empties the queue and the window and restores the default
// settings (pattern length 1, empty replacement).
module byte_stream_search_replace #(
   parameter int MAX_PATTERN     = bssr_pkg::DEFAULT_MAX_PATTERN,
   parameter int MAX_REPLACEMENT = bssr_pkg::DEFAULT_MAX_REPLACEMENT,
   parameter int QUEUE_DEPTH     = bssr_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_push,
   output logic                            req_full,
   input  bssr_pkg::req_item_type          req_item,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output bssr_pkg::rsp_item_type          rsp_item,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  bssr_pkg::csr_index_type         csr_index,
   input  logic [bssr_pkg::CSR_DATA_W-1:0] csr_data
);
   import bssr_pkg::*;

   logic    q_push;
   logic    q_full;
   logic    q_pop;
   logic    q_empty;
   job_type q_push_job;
   job_type q_head_job;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;

   bssr_front #(
      .MAX_PATTERN     (MAX_PATTERN),
      .MAX_REPLACEMENT (MAX_REPLACEMENT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_job     (q_push_job)
   );

   bssr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (q_head_job),
      .empty    (q_empty)
   );

   bssr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_job     (q_head_job),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

### hdl/bssr_checker.sv
`timescale 1ns / 1ps

module bssr_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input bssr_pkg::rsp_item_type rsp_item
);

   // nothing waits after reset
   a_reset_empty : assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result pending after reset");

   a_reset_not_full : assert property (@(posedge clock) reset |=> !req_full)
      else $error("input full after reset");

   // a bare item only ever closes a buffer
   a_bare_is_end : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.byte_valid) |-> rsp_item.end_of_output)
      else $error("bare item without end mark");

   a_bare_zero : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_item.byte_valid) |-> (rsp_item.out_byte == 8'd0))
      else $error("bare item carries data");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("stalled item changed");

endmodule

bind byte_stream_search_replace bssr_checker u_checker (.*);
